/* design/alil_pkg.sv */
package alil_pkg;

    // field widths of the transfer payloads
    localparam int KIND_W   = 3;
    localparam int POS_W    = 5;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int HPOS_W   = 4;
    localparam int COUNT_W  = 5;

    // default list size and the width of one find scan step
    localparam int DEFAULT_CAPACITY = 16;
    localparam int GROUP_W          = 8;
    localparam int LOG_GROUP        = 3;

    // operation codes
    typedef enum logic [KIND_W-1:0] {
        KIND_APPEND = 3'd0,
        KIND_INSERT = 3'd1,
        KIND_EDIT   = 3'd2,
        KIND_DELETE = 3'd3,
        KIND_GET    = 3'd4,
        KIND_FIND   = 3'd5
    } t_kind;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_BAD_INDEX = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    // what a cell does with its entry this cycle
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_LEFT,
        CELL_RIGHT
    } t_cell_op;

    // cell control: operation plus load value / find key
    typedef struct packed {
        t_cell_op          op;
        logic [DATA_W-1:0] data;
    } t_cell_ctl;

    // control sequencer states
    typedef enum logic {
        S_IDLE,
        S_SCAN
    } t_state;

endpackage

/* design/alil_in_if.sv */
interface alil_in_if;
    logic                         valid;
    logic                         ready;
    logic [alil_pkg::KIND_W-1:0]  kind;
    logic [alil_pkg::POS_W-1:0]   position;
    logic signed [alil_pkg::DATA_W-1:0] value;

    modport source (output valid, output kind, output position, output value, input ready);
    modport sink   (input valid, input kind, input position, input value, output ready);
endinterface

/* design/alil_out_if.sv */
interface alil_out_if;
    logic                          valid;
    logic                          ready;
    logic [alil_pkg::STATUS_W-1:0] status;
    logic signed [alil_pkg::DATA_W-1:0] read_value;
    logic                          hit;
    logic [alil_pkg::HPOS_W-1:0]   hit_position;
    logic [alil_pkg::COUNT_W-1:0]  element_count;

    modport source (output valid, output status, output read_value, output hit,
                    output hit_position, output element_count, input ready);
    modport sink   (input valid, input status, input read_value, input hit,
                    input hit_position, input element_count, output ready);
endinterface

/* design/alil_cell.sv */
module alil_cell (
    input  logic                        i_clk,
    input  alil_pkg::t_cell_ctl         i_ctl,
    input  logic [alil_pkg::DATA_W-1:0] i_left,
    input  logic [alil_pkg::DATA_W-1:0] i_right,
    output logic [alil_pkg::DATA_W-1:0] o_entry,
    output logic                        o_match
);
    import alil_pkg::*;

    logic [DATA_W-1:0] r_entry;

    // entry update: load, take from lower neighbour, take from upper neighbour
    always_ff @(posedge i_clk) begin
        unique case (i_ctl.op)
            CELL_LOAD:  r_entry <= i_ctl.data;
            CELL_LEFT:  r_entry <= i_left;
            CELL_RIGHT: r_entry <= i_right;
            default:    r_entry <= r_entry;
        endcase
    end

    // key compare
    assign o_entry = r_entry;
    assign o_match = (r_entry == i_ctl.data);
endmodule

/* design/array_list_insert_delete.sv */
// Ordered list engine holding up to CAPACITY signed 32-bit entries.
// Requests arrive on i_req (kind, position, value), one result per request
// leaves on o_rsp (status, read_value, hit, hit_position, element_count);
// both channels use valid/ready and a transfer happens when both are high.
// Append, insert, edit, delete and get complete in the accepting cycle:
// the result is registered and shows on o_rsp in the cycle after the request
// transfer, and the next request can be taken in that same cycle.
// Insert and delete shift the cells from the given position up by one place in that cycle.
// Find latches a match vector in the accepting cycle, then a scanner checks
// eight positions per cycle, stopping at the first hit and reporting the
// lowest matching position.
// One request is in flight at a time; i_req.ready is low during a find scan
// and while a finished result waits on a stalled o_rsp.
// Synchronous reset (i_rst_n low) empties the list and drops any pending
// result; entry contents are left as they are and are never read before
// being written.
module array_list_insert_delete #(
    parameter int CAPACITY = alil_pkg::DEFAULT_CAPACITY
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    alil_in_if.sink         i_req,
    alil_out_if.source      o_rsp
);
    import alil_pkg::*;

    localparam int IDX_W      = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int CMP_W      = POS_W + CNT_W;
    localparam int NGROUP     = (CAPACITY + GROUP_W - 1) / GROUP_W;
    localparam int GRP_W      = (NGROUP > 1) ? $clog2(NGROUP) : 1;
    localparam int SCAN_IDX_W = GRP_W + LOG_GROUP;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_fill, n_fill;
    logic [NGROUP*GROUP_W-1:0] r_match, n_match;
    logic [GRP_W-1:0]  r_scan_grp;

    logic              r_out_valid;
    t_status           r_out_status;
    logic [DATA_W-1:0] r_out_read;
    logic              r_out_hit;
    logic [HPOS_W-1:0] r_out_hpos;
    logic [COUNT_W-1:0] r_out_count;

    logic              in_ready, req_fire, out_free;
    t_kind             kind;
    logic [CMP_W-1:0]  pos_x, fill_x;
    logic              full;
    logic              do_append, do_insert, do_edit, do_delete;
    t_status           op_status;
    logic [DATA_W-1:0] op_read;

    logic [DATA_W-1:0] cell_entry [CAPACITY];
    logic [CAPACITY-1:0] cell_match;
    t_cell_ctl         cell_ctl [CAPACITY];

    logic [GROUP_W-1:0]    grp_bits;
    logic                  grp_hit;
    logic [LOG_GROUP-1:0]  grp_sel;
    logic                  scan_last, scan_done;
    logic [SCAN_IDX_W-1:0] scan_idx;
    logic [SCAN_IDX_W+HPOS_W-1:0] scan_idx_x;
    logic [CNT_W+COUNT_W-1:0]     n_fill_x, r_fill_x;

    // request decode
    assign kind     = t_kind'(i_req.kind);
    assign pos_x    = {{CNT_W{1'b0}}, i_req.position};
    assign fill_x   = {{POS_W{1'b0}}, r_fill};
    assign full     = (r_fill == CNT_W'(CAPACITY));
    assign out_free = !r_out_valid || o_rsp.ready;
    assign req_fire = i_req.valid && in_ready;

    // bounds and capacity checks
    always_comb begin
        do_append = 1'b0;
        do_insert = 1'b0;
        do_edit   = 1'b0;
        do_delete = 1'b0;
        op_status = ST_OK;
        op_read   = '0;
        unique case (kind)
            KIND_APPEND: begin
                if (full) op_status = ST_FULL;
                else      do_append = 1'b1;
            end
            KIND_INSERT: begin
                if (pos_x > fill_x) op_status = ST_BAD_INDEX;
                else if (full)      op_status = ST_FULL;
                else                do_insert = 1'b1;
            end
            KIND_EDIT: begin
                if (pos_x >= fill_x) op_status = ST_BAD_INDEX;
                else                 do_edit = 1'b1;
            end
            KIND_DELETE: begin
                if (pos_x >= fill_x) op_status = ST_BAD_INDEX;
                else                 do_delete = 1'b1;
            end
            KIND_GET: begin
                if (pos_x >= fill_x) op_status = ST_BAD_INDEX;
                else                 op_read = cell_entry[pos_x[IDX_W-1:0]];
            end
            default: begin
            end
        endcase
    end

    // new element count
    always_comb begin
        n_fill = r_fill;
        if (req_fire && (do_append || do_insert)) n_fill = r_fill + CNT_W'(1);
        else if (req_fire && do_delete)           n_fill = r_fill - CNT_W'(1);
    end

    // row of cells with per-cell shift control
    genvar k;
    generate
        for (k = 0; k < CAPACITY; k++) begin : g_cell
            logic [DATA_W-1:0] left_in, right_in;

            if (k == 0) begin : g_first
                assign left_in = cell_entry[k];
            end else begin : g_mid_l
                assign left_in = cell_entry[k-1];
            end
            if (k == CAPACITY - 1) begin : g_last
                assign right_in = cell_entry[k];
            end else begin : g_mid_r
                assign right_in = cell_entry[k+1];
            end

            always_comb begin
                cell_ctl[k].data = i_req.value;
                cell_ctl[k].op   = CELL_HOLD;
                if (req_fire) begin
                    if (do_append && (fill_x == CMP_W'(k)))
                        cell_ctl[k].op = CELL_LOAD;
                    else if ((do_insert || do_edit) && (pos_x == CMP_W'(k)))
                        cell_ctl[k].op = CELL_LOAD;
                    else if (do_insert && (CMP_W'(k) > pos_x))
                        cell_ctl[k].op = CELL_LEFT;
                    else if (do_delete && (CMP_W'(k) >= pos_x))
                        cell_ctl[k].op = CELL_RIGHT;
                end
            end

            alil_cell u_cell (
                .i_clk   (i_clk),
                .i_ctl   (cell_ctl[k]),
                .i_left  (left_in),
                .i_right (right_in),
                .o_entry (cell_entry[k]),
                .o_match (cell_match[k])
            );
        end
    endgenerate

    // match bits of the occupied cells
    always_comb begin
        n_match = '0;
        for (int m = 0; m < CAPACITY; m++)
            n_match[m] = cell_match[m] && (CNT_W'(m) < r_fill);
    end

    // find scanner: one group of match bits per cycle, lowest set bit wins
    assign grp_bits = r_match[r_scan_grp*GROUP_W +: GROUP_W];
    always_comb begin
        grp_hit = 1'b0;
        grp_sel = '0;
        for (int j = GROUP_W - 1; j >= 0; j--) begin
            if (grp_bits[j]) begin
                grp_hit = 1'b1;
                grp_sel = LOG_GROUP'(j);
            end
        end
    end
    assign scan_last  = (r_scan_grp == GRP_W'(NGROUP - 1));
    assign scan_done  = grp_hit || scan_last;
    assign scan_idx   = {r_scan_grp, grp_sel};
    assign scan_idx_x = {{HPOS_W{1'b0}}, scan_idx};
    assign n_fill_x   = {{COUNT_W{1'b0}}, n_fill};
    assign r_fill_x   = {{COUNT_W{1'b0}}, r_fill};

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (req_fire && (kind == KIND_FIND)) n_state = S_SCAN;
            S_SCAN: if (scan_done) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        unique case (r_state)
            S_IDLE:  in_ready = out_free;
            S_SCAN:  in_ready = 1'b0;
            default: in_ready = 1'b0;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            if (req_fire && (kind != KIND_FIND))
                r_out_valid <= 1'b1;
            else if (r_state == S_SCAN && scan_done)
                r_out_valid <= 1'b1;
            else if (o_rsp.ready)
                r_out_valid <= 1'b0;
        end
    end

    // match vector capture and scan position
    always_ff @(posedge i_clk) begin
        if (req_fire && (kind == KIND_FIND)) begin
            r_match    <= n_match;
            r_scan_grp <= '0;
        end else if (r_state == S_SCAN) begin
            r_scan_grp <= r_scan_grp + GRP_W'(1);
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (req_fire && (kind != KIND_FIND)) begin
            r_out_status <= op_status;
            r_out_read   <= op_read;
            r_out_hit    <= 1'b0;
            r_out_hpos   <= '0;
            r_out_count  <= n_fill_x[COUNT_W-1:0];
        end else if (r_state == S_SCAN && scan_done) begin
            r_out_status <= ST_OK;
            r_out_read   <= '0;
            r_out_hit    <= grp_hit;
            r_out_hpos   <= grp_hit ? scan_idx_x[HPOS_W-1:0] : '0;
            r_out_count  <= r_fill_x[COUNT_W-1:0];
        end
    end

    assign i_req.ready         = in_ready;
    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.status        = r_out_status;
    assign o_rsp.read_value    = r_out_read;
    assign o_rsp.hit           = r_out_hit;
    assign o_rsp.hit_position  = r_out_hpos;
    assign o_rsp.element_count = r_out_count;

    // checks
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CNT_W'(CAPACITY))
        else $error("element count above capacity");

    a_quick_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (req_fire && (kind != KIND_FIND)) |=> o_rsp.valid)
        else $error("result missing after single-cycle operation");

    a_scan_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (!o_rsp.valid && !i_req.ready))
        else $error("channel active during find scan");
endmodule

/* bench/tb_array_list_insert_delete.sv */
`timescale 1ns / 1ps

module tb_array_list_insert_delete;
    import alil_pkg::*;

    localparam int LIST_CAP     = DEFAULT_CAPACITY;
    localparam int RANDOM_OPS   = 1150;
    localparam int MAX_WAIT     = 19;
    localparam int DRAIN_LIMIT  = 5000;
    localparam int SETTLE_TIME  = 10;

    // kinds the block treats as no operation
    localparam logic [KIND_W-1:0] KIND_UNUSED_LO = 3'd6;
    localparam logic [KIND_W-1:0] KIND_UNUSED_HI = 3'd7;

    // extreme data words
    localparam logic [DATA_W-1:0] WORD_MIN = 32'h8000_0000;
    localparam logic [DATA_W-1:0] WORD_MAX = 32'h7fff_ffff;
    localparam logic [DATA_W-1:0] WORD_NEG = 32'hffff_ffff;

    typedef struct {
        logic [STATUS_W-1:0]      status;
        logic signed [DATA_W-1:0] read_value;
        logic                     hit;
        logic [HPOS_W-1:0]        hit_position;
        logic [COUNT_W-1:0]       element_count;
    } t_list_result;

    logic i_clk;
    logic i_rst_n;

    alil_in_if  req_if ();
    alil_out_if rsp_if ();

    array_list_insert_delete #(
        .CAPACITY (LIST_CAP)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // shadow copy of the list
    logic [DATA_W-1:0] list_words [LIST_CAP];
    int                list_len;

    t_list_result pending_results [$];
    bit           failed;
    bit           send_no_idle;

    // clock
    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // run limit
    initial begin
        #4_000_000;
        $display("Some tests failed");
        $finish;
    end

    // expected outcome of one operation, updating the shadow list
    function automatic t_list_result apply_list_op(input logic [KIND_W-1:0] k,
                                                   input logic [POS_W-1:0] p,
                                                   input logic [DATA_W-1:0] v);
        t_list_result r;
        int           idx;
        int           at;
        r.status        = ST_OK;
        r.read_value    = '0;
        r.hit           = 1'b0;
        r.hit_position  = '0;
        at              = int'(p);
        case (k)
            KIND_APPEND: begin
                if (list_len >= LIST_CAP) begin
                    r.status = ST_FULL;
                end else begin
                    list_words[list_len] = v;
                    list_len++;
                end
            end
            KIND_INSERT: begin
                // position check comes before the full check
                if (at > list_len) begin
                    r.status = ST_BAD_INDEX;
                end else if (list_len >= LIST_CAP) begin
                    r.status = ST_FULL;
                end else begin
                    for (idx = list_len; idx > at; idx--)
                        list_words[idx] = list_words[idx-1];
                    list_words[at] = v;
                    list_len++;
                end
            end
            KIND_EDIT: begin
                if (at >= list_len) r.status = ST_BAD_INDEX;
                else list_words[at] = v;
            end
            KIND_DELETE: begin
                if (at >= list_len) begin
                    r.status = ST_BAD_INDEX;
                end else begin
                    for (idx = at; idx + 1 < list_len; idx++)
                        list_words[idx] = list_words[idx+1];
                    list_len--;
                end
            end
            KIND_GET: begin
                if (at >= list_len) r.status = ST_BAD_INDEX;
                else r.read_value = list_words[at];
            end
            KIND_FIND: begin
                // first matching position wins
                for (idx = 0; idx < list_len; idx++) begin
                    if (!r.hit && list_words[idx] == v) begin
                        r.hit          = 1'b1;
                        r.hit_position = idx[HPOS_W-1:0];
                    end
                end
            end
            default: ;
        endcase
        r.element_count = list_len[COUNT_W-1:0];
        return r;
    endfunction

    // one request transfer; valid stays high for back-to-back items
    task automatic send_op(input logic [KIND_W-1:0] k, input logic [POS_W-1:0] p,
                           input logic [DATA_W-1:0] v);
        int gap;
        gap = send_no_idle ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid    <= 1'b1;
        req_if.kind     <= k;
        req_if.position <= p;
        req_if.value    <= v;
        do @(posedge i_clk); while (!req_if.ready);
        pending_results.push_back(apply_list_op(k, p, v));
    endtask

    // hold off new requests until every result is back or the drain limit runs out
    task automatic wait_for_results();
        int waited;
        waited = 0;
        req_if.valid <= 1'b0;
        while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
    endtask

    // data words: small values for duplicates, extremes, and full range
    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: pick_value = $urandom_range(0, 7) - 4;
            4:          pick_value = WORD_MIN;
            5:          pick_value = WORD_MAX;
            default:    pick_value = $urandom;
        endcase
    endfunction

    // operation mix leaning towards growth or shrinkage of the list
    function automatic logic [KIND_W-1:0] pick_kind(input bit growing);
        int roll;
        roll = $urandom_range(0, 99);
        if (growing) begin
            if (roll < 25)      pick_kind = KIND_APPEND;
            else if (roll < 50) pick_kind = KIND_INSERT;
            else if (roll < 60) pick_kind = KIND_EDIT;
            else if (roll < 70) pick_kind = KIND_DELETE;
            else if (roll < 85) pick_kind = KIND_GET;
            else                pick_kind = KIND_FIND;
        end else begin
            if (roll < 8)       pick_kind = KIND_APPEND;
            else if (roll < 16) pick_kind = KIND_INSERT;
            else if (roll < 26) pick_kind = KIND_EDIT;
            else if (roll < 70) pick_kind = KIND_DELETE;
            else if (roll < 85) pick_kind = KIND_GET;
            else                pick_kind = KIND_FIND;
        end
    endfunction

    // result checking with random back-pressure
    initial begin
        t_list_result want;
        int           stall;
        int           seen;
        seen = 0;
        rsp_if.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            // change receiver mode now and then, with calm stretches
            if (seen % 40 == 0) stall = ($urandom_range(0, 3) == 0) ? -1 : 0;
            if (stall >= 0) begin
                stall = $urandom_range(0, MAX_WAIT);
                if (stall > 0) begin
                    rsp_if.ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
            rsp_if.ready <= 1'b1;
            do @(posedge i_clk); while (!rsp_if.valid);
            seen++;
            if (pending_results.size() == 0) begin
                $error("unexpected result transfer");
                failed = 1'b1;
            end else begin
                want = pending_results.pop_front();
                if (rsp_if.status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, rsp_if.status);
                    failed = 1'b1;
                end
                if (rsp_if.read_value !== want.read_value) begin
                    $error("read_value: expected %0d, actual %0d",
                           want.read_value, rsp_if.read_value);
                    failed = 1'b1;
                end
                if (rsp_if.hit !== want.hit) begin
                    $error("hit: expected %0d, actual %0d", want.hit, rsp_if.hit);
                    failed = 1'b1;
                end
                if (rsp_if.hit_position !== want.hit_position) begin
                    $error("hit_position: expected %0d, actual %0d",
                           want.hit_position, rsp_if.hit_position);
                    failed = 1'b1;
                end
                if (rsp_if.element_count !== want.element_count) begin
                    $error("element_count: expected %0d, actual %0d",
                           want.element_count, rsp_if.element_count);
                    failed = 1'b1;
                end
            end
        end
    end

    // empty list: every index is out of range, unused kind does nothing
    task automatic test_empty_list();
        send_op(KIND_GET, 5'd0, '0);
        send_op(KIND_DELETE, 5'd0, '0);
        send_op(KIND_INSERT, 5'd1, 32'd7);
        send_op(KIND_UNUSED_LO, 5'd31, WORD_NEG);
    endtask

    // fill at head, middle and tail until the list is full
    task automatic test_fill_to_capacity();
        int i;
        send_op(KIND_INSERT, 5'd0, WORD_MIN);
        send_op(KIND_APPEND, 5'd0, WORD_MAX);
        send_op(KIND_INSERT, 5'd1, WORD_NEG);
        send_op(KIND_INSERT, 5'd3, '0);
        for (i = 4; i < LIST_CAP; i++) begin
            if (i == 8) send_op(KIND_INSERT, 5'd0, 32'h0f0f_0f0f);
            else send_op(KIND_APPEND, 5'd0, 32'ha5a5_0000 + i);
        end
    endtask

    // full list rejects growth; bad position is reported before full
    task automatic test_full_list();
        send_op(KIND_APPEND, 5'd0, 32'd1);
        send_op(KIND_INSERT, 5'd16, 32'd2);
        send_op(KIND_INSERT, 5'd17, 32'd3);
    endtask

    // edit, read, search and delete on a full list
    task automatic test_edit_get_delete();
        send_op(KIND_EDIT, 5'd15, 32'h5a5a_5a5a);
        send_op(KIND_GET, 5'd15, '0);
        send_op(KIND_GET, 5'd16, '0);
        send_op(KIND_FIND, 5'd0, WORD_NEG);
        send_op(KIND_DELETE, 5'd0, '0);
        send_op(KIND_UNUSED_HI, 5'd31, WORD_MIN);
    endtask

    // mostly well-formed operations on a list that swings between empty and full
    task automatic test_random_operations();
        int                n;
        bit                growing;
        logic [KIND_W-1:0] k;
        logic [POS_W-1:0]  p;
        logic [DATA_W-1:0] v;
        growing = 1'b1;
        for (n = 0; n < RANDOM_OPS; n++) begin
            if (n % 48 == 0) send_no_idle = ($urandom_range(0, 3) == 0);
            if (n % 300 == 299) wait_for_results();
            if (list_len == LIST_CAP && $urandom_range(0, 9) < 3) growing = 1'b0;
            if (list_len == 0) growing = 1'b1;
            if ($urandom_range(0, 49) == 0) growing = !growing;

            v = pick_value();
            if ($urandom_range(0, 99) < 6) begin
                // noise: any kind, any position
                k = KIND_W'($urandom_range(0, 7));
                p = POS_W'($urandom_range(0, 31));
                v = $urandom;
            end else begin
                k = pick_kind(growing);
                p = POS_W'($urandom_range(0, 31));
                if ($urandom_range(0, 9) != 0) begin
                    if (k == KIND_INSERT) p = POS_W'($urandom_range(0, list_len));
                    else if (list_len > 0) p = POS_W'($urandom_range(0, list_len - 1));
                end
                // search mostly for keys that are present
                if (k == KIND_FIND && list_len > 0 && $urandom_range(0, 9) < 7)
                    v = list_words[$urandom_range(0, list_len - 1)];
            end
            send_op(k, p, v);
        end
    endtask

    // main sequence
    initial begin
        failed          = 1'b0;
        send_no_idle    = 1'b0;
        list_len        = 0;
        i_rst_n         <= 1'b0;
        req_if.valid    <= 1'b0;
        req_if.kind     <= KIND_APPEND;
        req_if.position <= '0;
        req_if.value    <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_list();
        test_fill_to_capacity();
        test_full_list();
        wait_for_results();
        test_edit_get_delete();
        wait_for_results();
        test_random_operations();

        // drain, then let any stray result show up
        wait_for_results();
        repeat (SETTLE_TIME) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $error("%0d results never arrived", pending_results.size());
            failed = 1'b1;
        end
        if (!failed) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
